/* rtl/shacc_pkg.sv */
// Shared types and constants for the stripe hash accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package shacc_pkg;

  localparam int unsigned LANES            = 8;
  localparam int unsigned LANE_W           = 3;
  localparam int unsigned STRIPE_KEY_WORDS = 16;
  localparam int unsigned SCRAMBLE_SHIFT   = 47;
  localparam int unsigned HALF_BITS        = 32;
  localparam logic [31:0] MUL_PRIME        = 32'd2654435761;

  typedef enum logic [2:0] {
    KIND_KEY_WR = 3'd0,
    KIND_ACC_WR = 3'd1,
    KIND_LANE   = 3'd2,
    KIND_ACC_RD = 3'd3,
    KIND_START  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MUL_LANE   = 2'd0,
    MUL_SCR_LO = 2'd1,
    MUL_SCR_HI = 2'd2
  } mul_sel_t;

  typedef enum logic {
    SUM_ACC_VAL = 1'b0,
    SUM_PROD    = 1'b1
  } sum_sel_t;

  typedef struct packed {
    logic     key_wr;
    logic     acc_wr_in;
    logic     cnt_clr;
    logic     lane_rd;
    logic     scr_rd;
    logic     host_rd;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_en;
    sum_sel_t sum_sel;
    logic     acc_wr_res;
    logic     wr_scr;
    logic     lane_inc;
    logic     stripe_inc;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lane_last;
    logic stripe_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/shacc_ifs.sv */
// Valid/ready channel interfaces for the stripe hash accumulator.
// The input channel carries one command beat; the output channel one read beat.
interface shacc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  index;
  logic [63:0] value;
  logic        tail;

  modport source (output valid, output kind, output index, output value, output tail,
                  input ready);
  modport sink (input valid, input kind, input index, input value, input tail,
                output ready);
endinterface

interface shacc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;

  modport source (output valid, output read_value, input ready);
  modport sink (input valid, input read_value, output ready);
endinterface

/* rtl/shacc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the key table banks and the accumulators; no dependencies.
module shacc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/shacc_ctrl.sv */
// Controller state machine for the stripe hash accumulator.
// Decodes input beats and sequences the datapath; uses shacc_pkg.
module shacc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_kind,
  input  logic                 in_tail,
  input  shacc_pkg::dp_stat_t  stat,
  output shacc_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_LMUL  = 8'b0000_0100,
    S_LACC  = 8'b0000_1000,
    S_SC_RD = 8'b0001_0000,
    S_SC_M0 = 8'b0010_0000,
    S_SC_M1 = 8'b0100_0000,
    S_SC_WR = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   tail_r, tail_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    tail_nxt  = tail_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (shacc_pkg::kind_t'(in_kind))
            shacc_pkg::KIND_KEY_WR: cmd.key_wr = 1'b1;
            shacc_pkg::KIND_ACC_WR: cmd.acc_wr_in = 1'b1;
            shacc_pkg::KIND_LANE: begin
              cmd.lane_rd = 1'b1;
              tail_nxt    = in_tail;
              state_nxt   = S_LMUL;
            end
            shacc_pkg::KIND_ACC_RD: begin
              cmd.host_rd = 1'b1;
              state_nxt   = S_RD;
            end
            shacc_pkg::KIND_START: cmd.cnt_clr = 1'b1;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = shacc_pkg::MUL_LANE;
        cmd.sum_en  = 1'b1;
        cmd.sum_sel = shacc_pkg::SUM_ACC_VAL;
        state_nxt   = S_LACC;
      end
      S_LACC: begin
        cmd.acc_wr_res = 1'b1;
        cmd.lane_inc   = 1'b1;
        state_nxt      = S_IDLE;
        if (!tail_r && stat.lane_last) begin
          cmd.stripe_inc = 1'b1;
          if (stat.stripe_last) begin
            state_nxt = S_SC_RD;
          end
        end
      end
      S_SC_RD: begin
        cmd.scr_rd = 1'b1;
        state_nxt  = S_SC_M0;
      end
      S_SC_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = shacc_pkg::MUL_SCR_LO;
        state_nxt   = S_SC_M1;
      end
      S_SC_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = shacc_pkg::MUL_SCR_HI;
        cmd.sum_en  = 1'b1;
        cmd.sum_sel = shacc_pkg::SUM_PROD;
        state_nxt   = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.acc_wr_res = 1'b1;
        cmd.wr_scr     = 1'b1;
        cmd.lane_inc   = 1'b1;
        state_nxt      = stat.lane_last ? S_IDLE : S_SC_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
  end

endmodule

/* rtl/shacc_dp.sv */
// Datapath for the stripe hash accumulator: key and accumulator RAMs, the
// shared 32x32 multiplier, lane and stripe counters and the output register.
// Uses shacc_pkg and shacc_ram.
module shacc_dp #(
  parameter int KEY_WORDS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  shacc_pkg::ctrl_cmd_t cmd,
  output shacc_pkg::dp_stat_t  stat,
  input  logic [5:0]           in_index,
  input  logic [63:0]          in_value,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [63:0]          out_read_value
);

  localparam int SPB      = (KEY_WORDS - int'(shacc_pkg::STRIPE_KEY_WORDS)) / 2;
  localparam int SW       = $clog2(SPB);
  localparam int KEY_HALF = (KEY_WORDS + 1) / 2;
  localparam int KAW      = $clog2(KEY_HALF);
  localparam int SCR_BASE = SPB;

  logic [shacc_pkg::LANE_W-1:0] lane_count_r, lane_count_nxt;
  logic [SW-1:0]                stripe_count_r, stripe_count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [63:0]                  out_data_r;
  logic                         rd_zero_r;
  logic [63:0]                  val_r;
  logic [63:0]                  x_r;
  logic [63:0]                  prod_r;
  logic [63:0]                  sum_r;

  logic                         key_in_range;
  logic [8:0]                   key_half_wide;
  logic [KAW-1:0]               key_wr_addr;
  logic [KAW-1:0]               key_rd_addr;
  logic                         key_rd_en;
  logic [31:0]                  key_even;
  logic [31:0]                  key_odd;

  logic                         acc_wr_en;
  logic [shacc_pkg::LANE_W-1:0] acc_wr_addr;
  logic [63:0]                  acc_wr_data;
  logic                         acc_rd_en;
  logic [shacc_pkg::LANE_W-1:0] acc_rd_addr;
  logic [63:0]                  acc_rd;

  logic [63:0]                  x_now;
  logic [31:0]                  mul_a;
  logic [31:0]                  mul_b;
  logic [63:0]                  addend;
  logic                         stripe_last;

  // Key table is split into even and odd word banks so one lane reads its pair at once.
  assign key_in_range  = 9'(in_index) < 9'(KEY_WORDS);
  assign key_half_wide = 9'(in_index[5:1]);
  assign key_wr_addr   = key_half_wide[KAW-1:0];
  assign key_rd_en     = cmd.lane_rd | cmd.scr_rd;
  assign key_rd_addr   = cmd.scr_rd ? (KAW'(SCR_BASE) + KAW'(lane_count_r))
                                    : (KAW'(stripe_count_r) + KAW'(lane_count_r));

  shacc_ram #(
    .WIDTH (32),
    .DEPTH (KEY_HALF)
  ) u_key_even (
    .clk     (clk),
    .wr_en   (cmd.key_wr && key_in_range && !in_index[0]),
    .wr_addr (key_wr_addr),
    .wr_data (in_value[31:0]),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_even)
  );

  shacc_ram #(
    .WIDTH (32),
    .DEPTH (KEY_HALF)
  ) u_key_odd (
    .clk     (clk),
    .wr_en   (cmd.key_wr && key_in_range && in_index[0]),
    .wr_addr (key_wr_addr),
    .wr_data (in_value[31:0]),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_odd)
  );

  assign addend      = cmd.wr_scr ? {prod_r[31:0], 32'h0} : prod_r;
  assign acc_wr_en   = (cmd.acc_wr_in && (in_index[5:3] == 3'd0)) || cmd.acc_wr_res;
  assign acc_wr_addr = cmd.acc_wr_in ? in_index[2:0] : lane_count_r;
  assign acc_wr_data = cmd.acc_wr_in ? in_value : (sum_r + addend);
  assign acc_rd_en   = cmd.host_rd | cmd.lane_rd | cmd.scr_rd;
  assign acc_rd_addr = cmd.host_rd ? in_index[2:0] : lane_count_r;

  shacc_ram #(
    .WIDTH (64),
    .DEPTH (shacc_pkg::LANES)
  ) u_acc (
    .clk     (clk),
    .wr_en   (acc_wr_en),
    .wr_addr (acc_wr_addr),
    .wr_data (acc_wr_data),
    .rd_en   (acc_rd_en),
    .rd_addr (acc_rd_addr),
    .rd_data (acc_rd)
  );

  assign x_now = acc_rd ^ (acc_rd >> shacc_pkg::SCRAMBLE_SHIFT) ^ {key_odd, key_even};

  always_comb begin
    unique case (cmd.mul_sel)
      shacc_pkg::MUL_LANE: begin
        mul_a = val_r[31:0] ^ key_even;
        mul_b = val_r[63:32] ^ key_odd;
      end
      shacc_pkg::MUL_SCR_LO: begin
        mul_a = x_now[31:0];
        mul_b = shacc_pkg::MUL_PRIME;
      end
      shacc_pkg::MUL_SCR_HI: begin
        mul_a = x_r[63:32];
        mul_b = shacc_pkg::MUL_PRIME;
      end
      default: begin
        mul_a = 32'h0;
        mul_b = 32'h0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.lane_rd) begin
      val_r <= in_value;
    end
    if (cmd.host_rd) begin
      rd_zero_r <= (in_index[5:3] != 3'd0);
    end
    if (cmd.mul_en) begin
      prod_r <= {32'h0, mul_a} * {32'h0, mul_b};
    end
    if (cmd.mul_en && (cmd.mul_sel == shacc_pkg::MUL_SCR_LO)) begin
      x_r <= x_now;
    end
    if (cmd.sum_en) begin
      sum_r <= (cmd.sum_sel == shacc_pkg::SUM_PROD) ? prod_r : (acc_rd + val_r);
    end
    if (cmd.out_load) begin
      out_data_r <= rd_zero_r ? 64'h0 : acc_rd;
    end
  end

  assign stripe_last = (stripe_count_r == SW'(SPB - 1));

  always_comb begin
    lane_count_nxt   = lane_count_r;
    stripe_count_nxt = stripe_count_r;
    out_valid_nxt    = out_valid_r;
    if (cmd.cnt_clr) begin
      lane_count_nxt   = '0;
      stripe_count_nxt = '0;
    end
    if (cmd.lane_inc) begin
      lane_count_nxt = lane_count_r + 1'b1;
    end
    if (cmd.stripe_inc) begin
      stripe_count_nxt = stripe_last ? '0 : stripe_count_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_count_r   <= '0;
      stripe_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      lane_count_r   <= lane_count_nxt;
      stripe_count_r <= stripe_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign stat.lane_last   = (lane_count_r == 3'd7);
  assign stat.stripe_last = stripe_last;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

endmodule

/* rtl/stripe_hash_accumulator_core.sv */
// Stripe hash accumulator top level: controller and datapath on two beat channels.
// Key and accumulator writes complete in S_IDLE; a read waits in S_RD for a free output register.
// A data lane runs S_IDLE, S_LMUL, S_LACC; the lane closing a block adds a scramble of each
// accumulator (S_SC_RD through S_SC_WR on the shared 32x32 multiplier and the accumulator RAM port).
// Reset (rst_n low, synchronous) clears the state machine, lane and stripe counters and
// the output valid; the key table and accumulators keep their contents until written.
module stripe_hash_accumulator_core #(
  parameter int KEY_WORDS = 48
) (
  input logic          clk,
  input logic          rst_n,
  shacc_in_if.sink     in_ch,
  shacc_out_if.source  out_ch
);

  shacc_pkg::ctrl_cmd_t cmd;
  shacc_pkg::dp_stat_t  stat;

  shacc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_kind  (in_ch.kind),
    .in_tail  (in_ch.tail),
    .stat     (stat),
    .cmd      (cmd)
  );

  shacc_dp #(
    .KEY_WORDS (KEY_WORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_index       (in_ch.index),
    .in_value       (in_ch.value),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_read_value (out_ch.read_value)
  );

endmodule
